// File: sv/i4p_pkg.sv
// Package for the 4x4 luma intra predictor: request and response types,
// mode codes and the rounded 2-tap and 3-tap averages.
// No dependencies.
`default_nettype none

package i4p_pkg;

   typedef logic [7:0] pix_type;
   typedef pix_type [7:0] top_arr_type;
   typedef pix_type [3:0] left_arr_type;
   typedef pix_type [15:0] blk_type;

   typedef struct packed {
      logic [63:0] top_row;
      logic [31:0] left_column;
      logic [7:0]  corner_pixel;
      logic [3:0]  opcode;
   } req_type;

   typedef struct packed {
      logic [63:0] upper_rows;
      logic [63:0] lower_rows;
   } rsp_type;

   localparam logic [3:0] OP_VERT    = 4'd0;
   localparam logic [3:0] OP_HORIZ   = 4'd1;
   localparam logic [3:0] OP_DC      = 4'd2;
   localparam logic [3:0] OP_DDL     = 4'd3;
   localparam logic [3:0] OP_DDR     = 4'd4;
   localparam logic [3:0] OP_VR      = 4'd5;
   localparam logic [3:0] OP_HD      = 4'd6;
   localparam logic [3:0] OP_VL      = 4'd7;
   localparam logic [3:0] OP_HU      = 4'd8;
   localparam logic [3:0] OP_DC_TOP  = 4'd9;
   localparam logic [3:0] OP_DC_LEFT = 4'd10;
   localparam logic [3:0] OP_FLAT    = 4'd11;

   localparam pix_type FLAT_VALUE = 8'd128;

   function automatic pix_type avg2(input pix_type a, input pix_type b);
      logic [8:0] s;
      s = {1'b0, a} + {1'b0, b} + 9'd1;
      return s[8:1];
   endfunction

   function automatic pix_type avg3(input pix_type a, input pix_type b, input pix_type c);
      logic [9:0] s;
      s = {2'b00, a} + {1'b0, b, 1'b0} + {2'b00, c} + 10'd2;
      return s[9:2];
   endfunction

endpackage

`default_nettype wire

// File: sv/intra_4x4_luma_predictor.sv
// Top level of the 4x4 luma intra predictor: request register, prediction
// logic, response register. Depends on i4p_pkg and i4p_predict.
//
//   channel   ports                      handshake
//   request   start, busy, req_payload   taken when start && !busy
//   response  rsp_valid, rsp_payload     one-cycle strobe, no back-pressure
//
// A request passes through the request register, then the response register.
// One request per cycle; busy is held low, nothing in the path can stall.
// Synchronous reset clears the valid flags only; payload registers hold.
`default_nettype none

module intra_4x4_luma_predictor (
   input  var logic             clock,
   input  var logic             reset,
   input  var logic             start,
   output var logic             busy,
   input  var i4p_pkg::req_type req_payload,
   output var logic             rsp_valid,
   output var i4p_pkg::rsp_type rsp_payload
);
   import i4p_pkg::*;

   req_type req_ff;
   logic    req_valid_ff;
   logic    req_valid_in;
   rsp_type rsp_in;
   rsp_type rsp_ff;
   logic    rsp_valid_ff;

   assign busy         = 1'b0;
   assign req_valid_in = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= req_valid_ff;
      end
      if (req_valid_in) begin
         req_ff <= req_payload;
      end
      if (req_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   i4p_predict u_predict (
      .req (req_ff),
      .rsp (rsp_in)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_two_cycle: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_valid)
      else $error("response missing two cycles after request");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(req_valid_ff))
      else $error("response without request");

   a_flat: assert property (@(posedge clock) disable iff (reset)
      (req_valid_ff && req_ff.opcode == OP_FLAT) |=>
      (rsp_payload.upper_rows == {8{FLAT_VALUE}} && rsp_payload.lower_rows == {8{FLAT_VALUE}}))
      else $error("flat mode not 128");

   a_vert: assert property (@(posedge clock) disable iff (reset)
      (req_valid_ff && req_ff.opcode == OP_VERT) |=>
      (rsp_payload.lower_rows[31:0] == $past(req_ff.top_row[31:0])))
      else $error("vertical mode row mismatch");

endmodule

`default_nettype wire

// File: sv/i4p_predict.sv
// Combinational 4x4 luma intra prediction: sixteen pixels from the
// thirteen neighbours and the mode. Depends on i4p_pkg.
`default_nettype none

module i4p_predict (
   input  var i4p_pkg::req_type req,
   output var i4p_pkg::rsp_type rsp
);
   import i4p_pkg::*;

   top_arr_type  top;
   left_arr_type left;
   pix_type      corner;
   logic [9:0]   sum_top;
   logic [9:0]   sum_left;
   logic [9:0]   dc_top_sum;
   logic [9:0]   dc_left_sum;
   logic [10:0]  dc_all_sum;
   pix_type      dc_top;
   pix_type      dc_left;
   pix_type      dc_all;
   blk_type      pred;

   // negative index selects the corner
   function automatic pix_type tp(input top_arr_type t, input pix_type c, input int i);
      if (i < 0) return c;
      return t[i[2:0]];
   endfunction

   function automatic pix_type lp(input left_arr_type l, input pix_type c, input int i);
      if (i < 0) return c;
      return l[i[1:0]];
   endfunction

   assign top    = req.top_row;
   assign left   = req.left_column;
   assign corner = req.corner_pixel;

   assign sum_top  = {2'b00, top[0]} + {2'b00, top[1]} + {2'b00, top[2]} + {2'b00, top[3]};
   assign sum_left = {2'b00, left[0]} + {2'b00, left[1]} + {2'b00, left[2]}
                   + {2'b00, left[3]};

   assign dc_top_sum  = sum_top + 10'd2;
   assign dc_left_sum = sum_left + 10'd2;
   assign dc_all_sum  = {1'b0, sum_top} + {1'b0, sum_left} + 11'd4;
   assign dc_top      = dc_top_sum[9:2];
   assign dc_left     = dc_left_sum[9:2];
   assign dc_all      = dc_all_sum[10:3];

   for (genvar y = 0; y < 4; y++) begin : g_row
      for (genvar x = 0; x < 4; x++) begin : g_col
         localparam int N  = 4 * y + x;
         localparam int ZV = 2 * x - y;
         localparam int KV = x - (y >> 1);
         localparam int ZH = 2 * y - x;
         localparam int KH = y - (x >> 1);
         localparam int KL = x + (y >> 1);
         localparam int ZU = x + 2 * y;
         localparam int KU = y + (x >> 1);

         pix_type pix;

         always_comb begin
            case (req.opcode)
               OP_VERT:  pix = tp(top, corner, x);
               OP_HORIZ: pix = lp(left, corner, y);
               OP_DC:    pix = dc_all;
               OP_DDL: begin
                  if (x == 3 && y == 3) pix = avg3(top[6], top[7], top[7]);
                  else pix = avg3(tp(top, corner, x + y), tp(top, corner, x + y + 1),
                                  tp(top, corner, x + y + 2));
               end
               OP_DDR: begin
                  if (x > y)
                     pix = avg3(tp(top, corner, x - y - 2), tp(top, corner, x - y - 1),
                                tp(top, corner, x - y));
                  else if (x < y)
                     pix = avg3(lp(left, corner, y - x - 2), lp(left, corner, y - x - 1),
                                lp(left, corner, y - x));
                  else
                     pix = avg3(top[0], corner, left[0]);
               end
               OP_VR: begin
                  if (ZV >= 0 && (ZV % 2) == 0)
                     pix = avg2(tp(top, corner, KV - 1), tp(top, corner, KV));
                  else if (ZV >= 0)
                     pix = avg3(tp(top, corner, KV - 2), tp(top, corner, KV - 1),
                                tp(top, corner, KV));
                  else if (ZV == -1)
                     pix = avg3(left[0], corner, top[0]);
                  else
                     pix = avg3(lp(left, corner, y - 1), lp(left, corner, y - 2),
                                lp(left, corner, y - 3));
               end
               OP_HD: begin
                  if (ZH >= 0 && (ZH % 2) == 0)
                     pix = avg2(lp(left, corner, KH - 1), lp(left, corner, KH));
                  else if (ZH >= 0)
                     pix = avg3(lp(left, corner, KH - 2), lp(left, corner, KH - 1),
                                lp(left, corner, KH));
                  else if (ZH == -1)
                     pix = avg3(left[0], corner, top[0]);
                  else
                     pix = avg3(tp(top, corner, x - 1), tp(top, corner, x - 2),
                                tp(top, corner, x - 3));
               end
               OP_VL: begin
                  if ((y % 2) == 0)
                     pix = avg2(tp(top, corner, KL), tp(top, corner, KL + 1));
                  else
                     pix = avg3(tp(top, corner, KL), tp(top, corner, KL + 1),
                                tp(top, corner, KL + 2));
               end
               OP_HU: begin
                  if (ZU > 5)
                     pix = left[3];
                  else if (ZU == 5)
                     pix = avg3(left[2], left[3], left[3]);
                  else if ((ZU % 2) == 0)
                     pix = avg2(lp(left, corner, KU), lp(left, corner, KU + 1));
                  else
                     pix = avg3(lp(left, corner, KU), lp(left, corner, KU + 1),
                                lp(left, corner, KU + 2));
               end
               OP_DC_TOP:  pix = dc_top;
               OP_DC_LEFT: pix = dc_left;
               OP_FLAT:    pix = FLAT_VALUE;
               default:    pix = '0;
            endcase
         end

         assign pred[N] = pix;
      end
   end

   assign rsp.upper_rows = pred[7:0];
   assign rsp.lower_rows = pred[15:8];

endmodule

`default_nettype wire
